### hw/rtl/ssc_pkg.sv
// Shared types, codes and round functions for the stream cipher with MAC.
`timescale 1ns / 1ps
package ssc_pkg;

   localparam int NWORDS = 16;
   localparam int KEY_POS = 13;
   localparam int FOLD_ROUNDS = 16;
   localparam logic [31:0] INIT_KONST = 32'h6996c53a;

   typedef enum logic [2:0] {
      OP_KEY_BYTE   = 3'd0,
      OP_KEY_END    = 3'd1,
      OP_NONCE_BYTE = 3'd2,
      OP_NONCE_END  = 3'd3,
      OP_ENCRYPT    = 3'd4,
      OP_DECRYPT    = 3'd5,
      OP_FINISH     = 3'd6,
      OP_UNUSED     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_KEY   = 2'd1,
      PHASE_NONCE = 2'd2
   } phase_type;

   typedef struct packed {
      op_type     operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  result_byte;
      logic [31:0] mac_word;
      logic        is_mac;
   } rsp_type;

   // datapath commands, one per cycle
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_START_KEY,    // Fibonacci words, clear packer
      CMD_START_NONCE,  // reload saved words, clear packer
      CMD_LOAD_BYTE,    // pack byte; fold and clock if word full
      CMD_FOLD_PACK,    // fold partial packed word and clock
      CMD_FOLD_LEN,     // fold length and clock, copy to crc
      CMD_CLOCK,        // one register clock
      CMD_XOR_CRC,      // reg ^= crc
      CMD_END_LOAD,     // konst, optional save, clear counters
      CMD_STREAM,       // encrypt or decrypt one byte
      CMD_FIN_MAC,      // MAC partial word
      CMD_FIN_KEY,      // clock, fold final word, xor crc
      CMD_FIN_OUT       // last clock, present MAC
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       save;
      logic       decrypt;
      logic [7:0] data_byte;
   } dp_ctl_type;

   typedef struct packed {
      logic need_pack;   // partial word waits
   } dp_sts_type;

   function automatic logic [31:0] rol(input logic [31:0] x, input int c);
      rol = (x << c) | (x >> (32 - c));
   endfunction

   function automatic logic [31:0] mix_a(input logic [31:0] w);
      logic [31:0] v;
      v = w ^ (rol(w, 5) | rol(w, 7));
      mix_a = v ^ (rol(v, 19) | rol(v, 22));
   endfunction

   function automatic logic [31:0] mix_b(input logic [31:0] w);
      logic [31:0] v;
      v = w ^ (rol(w, 7) | rol(w, 22));
      mix_b = v ^ (rol(v, 5) | rol(v, 19));
   endfunction

   function automatic logic [31:0] fib_word(input int i);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] t;
      a = 32'd1;
      b = 32'd1;
      fib_word = 32'd0;
      for (int k = 0; k < NWORDS; k++) begin
         if (k == i) fib_word = a;
         t = a + b;
         a = b;
         b = t;
      end
   endfunction

endpackage

### hw/rtl/shannon_stream_cipher_mac.sv
// Top level of the stream cipher with MAC: controller plus datapath.
// Latency: encrypt and decrypt results are valid the cycle after acceptance.
// Throughput: one key, nonce or data byte per cycle unless stalled (a register clock per 4 bytes).
// Key end and nonce end stall input through pack, length, 16 rounds, crc and close.
// Finish stalls input through MAC, key, 16 rounds and output; the MAC waits for a free output.
// Reset (synchronous, active high) clears all register, CRC and saved state to zero.
`timescale 1ns / 1ps
module shannon_stream_cipher_mac import ssc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dp_ctl_type ctl;
   dp_sts_type sts;
   logic       rsp_take;
   logic       load_op;

   // a request byte for key or nonce loads is packed in its accept cycle
   assign load_op = req_valid && !req_stall &&
                    (req_data.operation == OP_KEY_BYTE ||
                     req_data.operation == OP_NONCE_BYTE);

   ssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_take  (rsp_take),
      .ctl       (ctl),
      .sts       (sts)
   );

   ssc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .load_op  (load_op),
      .rsp_take (rsp_take),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

### hw/rtl/ssc_ctrl.sv
// Controller state machine sequencing loads, stream bytes and finish.
`timescale 1ns / 1ps
module ssc_ctrl import ssc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_take,
   output dp_ctl_type ctl,
   input  dp_sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_END_PACK, ST_END_LEN, ST_END_CLK, ST_END_XOR, ST_END_FIN,
      ST_FIN_MAC, ST_FIN_KEY, ST_FIN_CLK, ST_FIN_OUT
   } st_type;

   st_type     state_ff, state_in;
   phase_type  phase_ff, phase_in;
   logic [4:0] count_ff, count_in;
   logic       save_ff, save_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign rsp_valid = valid_ff;
   // one held result at most; a stream byte is accepted only when no held result is stalled
   assign req_stall = (state_ff != ST_IDLE) || (valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      save_in  = save_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_KEY_BYTE, OP_NONCE_BYTE: begin
                     phase_in = (req_data.operation == OP_KEY_BYTE) ? PHASE_KEY
                                                                   : PHASE_NONCE;
                  end
                  OP_KEY_END, OP_NONCE_END: begin
                     save_in  = (req_data.operation == OP_KEY_END);
                     phase_in = PHASE_IDLE;
                     state_in = ST_END_PACK;
                  end
                  OP_ENCRYPT, OP_DECRYPT: phase_in = PHASE_IDLE;
                  OP_FINISH: begin
                     phase_in = PHASE_IDLE;
                     state_in = ST_FIN_MAC;
                  end
                  default: ;
               endcase
            end
         end
         ST_END_PACK: state_in = ST_END_LEN;
         ST_END_LEN: begin
            count_in = '0;
            state_in = ST_END_CLK;
         end
         ST_END_CLK: begin
            count_in = count_ff + 5'd1;
            if (count_ff == 5'(FOLD_ROUNDS - 1)) state_in = ST_END_XOR;
         end
         ST_END_XOR: state_in = ST_END_FIN;
         ST_END_FIN: state_in = ST_IDLE;
         ST_FIN_MAC: state_in = ST_FIN_KEY;
         ST_FIN_KEY: begin
            count_in = '0;
            state_in = ST_FIN_CLK;
         end
         ST_FIN_CLK: begin
            count_in = count_ff + 5'd1;
            if (count_ff == 5'(FOLD_ROUNDS - 1)) state_in = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            if (!(valid_ff && rsp_stall)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output decode
   always_comb begin
      ctl.cmd       = CMD_NONE;
      ctl.save      = save_ff;
      ctl.decrypt   = (req_data.operation == OP_DECRYPT);
      ctl.data_byte = req_data.data_byte;
      valid_in      = valid_ff && rsp_stall;
      rsp_take      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_KEY_BYTE, OP_KEY_END:
                     ctl.cmd = (phase_ff != PHASE_KEY) ? CMD_START_KEY : CMD_NONE;
                  OP_NONCE_BYTE, OP_NONCE_END:
                     ctl.cmd = (phase_ff != PHASE_NONCE) ? CMD_START_NONCE : CMD_NONE;
                  OP_ENCRYPT, OP_DECRYPT: begin
                     ctl.cmd  = CMD_STREAM;
                     valid_in = 1'b1;
                     rsp_take = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_END_PACK: ctl.cmd = sts.need_pack ? CMD_FOLD_PACK : CMD_NONE;
         ST_END_LEN:  ctl.cmd = CMD_FOLD_LEN;
         ST_END_CLK:  ctl.cmd = CMD_CLOCK;
         ST_END_XOR:  ctl.cmd = CMD_XOR_CRC;
         ST_END_FIN:  ctl.cmd = CMD_END_LOAD;
         ST_FIN_MAC:  ctl.cmd = CMD_FIN_MAC;
         ST_FIN_KEY:  ctl.cmd = CMD_FIN_KEY;
         ST_FIN_CLK:  ctl.cmd = CMD_CLOCK;
         ST_FIN_OUT: begin
            if (!(valid_ff && rsp_stall)) begin
               ctl.cmd  = CMD_FIN_OUT;
               valid_in = 1'b1;
               rsp_take = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_IDLE;
         count_ff <= '0;
         save_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
         save_ff  <= save_in;
         valid_ff <= valid_in;
      end
   end

   // byte loads issue no pack command; a possible start and the load are merged
   // by the datapath in the same cycle, via load_op from the top level.

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("request taken while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_OUT && !(valid_ff && rsp_stall)) |=> (state_ff == ST_IDLE && rsp_valid))
      else $error("finish result missing");

endmodule

### hw/rtl/ssc_dp.sv
// Datapath: register file, CRC file, saved keyed state, packer and MAC word.
`timescale 1ns / 1ps
module ssc_dp import ssc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  dp_ctl_type ctl,
   input  logic       load_op,   // accepted key or nonce byte
   input  logic       rsp_take,
   output dp_sts_type sts,
   output rsp_type    rsp_data
);

   logic [31:0] reg_ff   [NWORDS];
   logic [31:0] reg_in   [NWORDS];
   logic [31:0] crc_ff   [NWORDS];
   logic [31:0] crc_in   [NWORDS];
   logic [31:0] save_ff  [NWORDS];
   logic [31:0] save_in  [NWORDS];
   logic [31:0] konst_ff, konst_in;
   logic [31:0] strm_ff, strm_in;
   logic [31:0] mac_ff, mac_in;
   logic [5:0]  bits_ff, bits_in;
   logic [31:0] pack_ff, pack_in;
   logic [1:0]  pcnt_ff, pcnt_in;
   logic [31:0] len_ff, len_in;
   rsp_type     out_ff, out_in;

   // working copies for a chain of at most: fold -> clock -> fold
   logic [31:0] w    [NWORDS];
   logic [31:0] c    [NWORDS];
   logic [31:0] t;
   logic [31:0] ks_word;
   logic [31:0] pw;
   logic [5:0]  bl;
   logic [4:0]  sh;
   logic [7:0]  ks, res, plain;
   logic [31:0] macv;
   logic [1:0]  pc;
   logic        do_clock;
   logic        do_mac;
   logic [31:0] mac_w;

   assign sts.need_pack = (pcnt_ff != 2'd0);
   assign rsp_data = out_ff;

   always_comb begin
      for (int i = 0; i < NWORDS; i++) begin
         w[i] = reg_ff[i];
         c[i] = crc_ff[i];
         save_in[i] = save_ff[i];
      end
      konst_in = konst_ff;
      strm_in  = strm_ff;
      mac_in   = mac_ff;
      bits_in  = bits_ff;
      pack_in  = pack_ff;
      pcnt_in  = pcnt_ff;
      len_in   = len_ff;
      out_in   = out_ff;
      do_clock = 1'b0;
      do_mac   = 1'b0;
      mac_w    = mac_ff;
      pw       = pack_ff;
      pc       = pcnt_ff;
      ks       = '0;
      res      = '0;
      plain    = '0;
      bl       = bits_ff;
      sh       = '0;
      macv     = mac_ff;
      ks_word  = strm_ff;

      // load start, possibly in the same cycle as a byte
      if (ctl.cmd == CMD_START_KEY || ctl.cmd == CMD_START_NONCE) begin
         for (int i = 0; i < NWORDS; i++)
            w[i] = (ctl.cmd == CMD_START_KEY) ? fib_word(i) : save_ff[i];
         konst_in = INIT_KONST;
         len_in   = '0;
         pw       = '0;
         pc       = '0;
      end

      unique case (ctl.cmd)
         CMD_FOLD_PACK: begin
            w[KEY_POS] = w[KEY_POS] ^ pack_ff;
            do_clock   = 1'b1;
         end
         CMD_FOLD_LEN: begin
            w[KEY_POS] = w[KEY_POS] ^ len_ff;
            do_clock   = 1'b1;
         end
         CMD_CLOCK: do_clock = 1'b1;
         CMD_STREAM: begin
            if (bits_ff == 6'd0) begin
               do_clock = 1'b1;
               macv     = '0;
               bl       = 6'd32;
            end
         end
         CMD_FIN_MAC: do_mac = (bits_ff != 6'd0);
         CMD_FIN_KEY: do_clock = 1'b1;
         CMD_FIN_OUT: do_clock = 1'b1;
         default: ;
      endcase

      // byte load (after any start)
      if (load_op) begin
         pw     = pw | ({24'd0, ctl.data_byte} << {pc, 3'b000});
         len_in = len_in + 32'd1;
         if (pc == 2'd3) begin
            w[KEY_POS] = w[KEY_POS] ^ pw;
            do_clock   = 1'b1;
            pw         = '0;
            pc         = '0;
         end else begin
            pc = pc + 2'd1;
         end
      end
      pack_in = pw;
      pcnt_in = pc;

      // one register clock
      if (do_clock) begin
         t = mix_a(w[12] ^ w[13] ^ konst_ff) ^ rol(w[0], 1);
         for (int i = 0; i < NWORDS - 1; i++) w[i] = w[i + 1];
         w[NWORDS - 1] = t;
         t = mix_b(w[2] ^ w[15]);
         w[0] = w[0] ^ t;
         ks_word = t ^ w[8] ^ w[12];
         strm_in = ks_word;
      end else begin
         t = '0;
      end

      unique case (ctl.cmd)
         CMD_FOLD_LEN: for (int i = 0; i < NWORDS; i++) c[i] = w[i];
         CMD_XOR_CRC: for (int i = 0; i < NWORDS; i++) w[i] = w[i] ^ crc_ff[i];
         CMD_END_LOAD: begin
            konst_in = reg_ff[0];
            if (ctl.save) for (int i = 0; i < NWORDS; i++) save_in[i] = reg_ff[i];
            bits_in = '0;
            pack_in = '0;
            pcnt_in = '0;
         end
         CMD_STREAM: begin
            sh    = 5'(6'd32 - bl);
            ks    = 8'(ks_word >> sh);
            res   = ctl.data_byte ^ ks;
            plain = ctl.decrypt ? res : ctl.data_byte;
            macv  = macv ^ ({24'd0, plain} << sh);
            bl    = bl - 6'd8;
            mac_in  = macv;
            bits_in = bl;
            if (bl == 6'd0) begin
               do_mac = 1'b1;
               mac_w  = macv;
            end
            out_in.result_byte = res;
            out_in.mac_word    = '0;
            out_in.is_mac      = 1'b0;
         end
         CMD_FIN_KEY: begin
            w[KEY_POS] = w[KEY_POS] ^ INIT_KONST ^ {23'd0, bits_ff, 3'b000};
            bits_in = '0;
            for (int i = 0; i < NWORDS; i++) w[i] = w[i] ^ crc_ff[i];
         end
         CMD_FIN_OUT: begin
            out_in.result_byte = '0;
            out_in.mac_word    = ks_word;
            out_in.is_mac      = 1'b1;
         end
         default: ;
      endcase

      // MAC a completed plaintext word, or the partial word at finish
      if (do_mac) begin
         for (int i = 0; i < NWORDS - 1; i++) c[i] = crc_ff[i + 1];
         c[NWORDS - 1] = crc_ff[0] ^ crc_ff[2] ^ crc_ff[15] ^ mac_w;
         w[KEY_POS] = w[KEY_POS] ^ mac_w;
      end

      for (int i = 0; i < NWORDS; i++) begin
         reg_in[i] = w[i];
         crc_in[i] = c[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NWORDS; i++) begin
            reg_ff[i]  <= '0;
            crc_ff[i]  <= '0;
            save_ff[i] <= '0;
         end
         konst_ff <= '0;
         strm_ff  <= '0;
         mac_ff   <= '0;
         bits_ff  <= '0;
         pack_ff  <= '0;
         pcnt_ff  <= '0;
         len_ff   <= '0;
      end else begin
         for (int i = 0; i < NWORDS; i++) begin
            reg_ff[i]  <= reg_in[i];
            crc_ff[i]  <= crc_in[i];
            save_ff[i] <= save_in[i];
         end
         konst_ff <= konst_in;
         strm_ff  <= strm_in;
         mac_ff   <= mac_in;
         bits_ff  <= bits_in;
         pack_ff  <= pack_in;
         pcnt_ff  <= pcnt_in;
         len_ff   <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) out_ff <= out_in;
   end

   a_bits_step: assert property (@(posedge clock) disable iff (reset)
      (bits_ff[2:0] == 3'd0)) else $error("keystream bit count off byte grid");
   a_stream_bits: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_STREAM) |=> (bits_ff != 6'd32)) else $error("bit count not consumed");
   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      (ctl.cmd == CMD_END_LOAD) |=> (pcnt_ff == 2'd0 && bits_ff == 6'd0))
      else $error("load end left counters");

endmodule

### dv/tb_top.sv
// Testbench for shannon_stream_cipher_mac: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
   import ssc_pkg::*;

   // Scoreboard: owns the cipher state predictor and the queue of expected results.
   class cipher_scoreboard;
      logic [31:0] regs [16];
      logic [31:0] crcs [16];
      logic [31:0] saved [16];
      logic [31:0] konst, keystream, mac_acc, load_len, pack;
      int unsigned bits_left, pack_cnt;
      phase_type phase;
      rsp_type pending[$];
      int unsigned mismatches;

      function new();
         for (int i = 0; i < 16; i++) begin
            regs[i] = '0;
            crcs[i] = '0;
            saved[i] = '0;
         end
         konst = '0; keystream = '0; mac_acc = '0; load_len = '0; pack = '0;
         bits_left = 0; pack_cnt = 0; phase = PHASE_IDLE; mismatches = 0;
      endfunction

      function logic [31:0] rotl(logic [31:0] x, int c);
         return (x << c) | (x >> (32 - c));
      endfunction

      function logic [31:0] diffuse_fwd(logic [31:0] w);
         logic [31:0] v;
         v = w ^ (rotl(w, 5) | rotl(w, 7));
         return v ^ (rotl(v, 19) | rotl(v, 22));
      endfunction

      function logic [31:0] diffuse_rev(logic [31:0] w);
         logic [31:0] v;
         v = w ^ (rotl(w, 7) | rotl(w, 22));
         return v ^ (rotl(v, 5) | rotl(v, 19));
      endfunction

      function void advance();
         logic [31:0] t;
         t = diffuse_fwd(regs[12] ^ regs[13] ^ konst) ^ rotl(regs[0], 1);
         for (int i = 1; i < 16; i++) regs[i-1] = regs[i];
         regs[15] = t;
         t = diffuse_rev(regs[2] ^ regs[15]);
         regs[0] ^= t;
         keystream = t ^ regs[8] ^ regs[12];
      endfunction

      function void absorb_word(logic [31:0] w);
         logic [31:0] t;
         t = crcs[0] ^ crcs[2] ^ crcs[15] ^ w;
         for (int i = 1; i < 16; i++) crcs[i-1] = crcs[i];
         crcs[15] = t;
         regs[KEY_POS] ^= w;
      endfunction

      function void begin_load(phase_type p);
         if (p == PHASE_KEY) begin
            regs[0] = 1; regs[1] = 1;
            for (int i = 2; i < 16; i++) regs[i] = regs[i-1] + regs[i-2];
         end else begin
            for (int i = 0; i < 16; i++) regs[i] = saved[i];
         end
         konst = INIT_KONST; load_len = 0; pack = 0; pack_cnt = 0; phase = p;
      endfunction

      function void pack_byte(logic [7:0] b);
         pack |= 32'(b) << (8 * pack_cnt);
         load_len += 1;
         if (pack_cnt == 3) begin
            regs[KEY_POS] ^= pack;
            advance();
            pack = 0; pack_cnt = 0;
         end else pack_cnt++;
      endfunction

      function void close_load(bit is_key);
         if (pack_cnt != 0) begin
            regs[KEY_POS] ^= pack;
            advance();
         end
         regs[KEY_POS] ^= load_len;
         advance();
         for (int i = 0; i < 16; i++) crcs[i] = regs[i];
         for (int i = 0; i < FOLD_ROUNDS; i++) advance();
         for (int i = 0; i < 16; i++) regs[i] ^= crcs[i];
         konst = regs[0];
         if (is_key) for (int i = 0; i < 16; i++) saved[i] = regs[i];
         bits_left = 0; pack = 0; pack_cnt = 0; phase = PHASE_IDLE;
      endfunction

      // note an accepted request, queue its result if it has one
      function void note_request(req_type r);
         rsp_type e;
         logic [7:0] ks, res, plain;
         e = '0;
         case (r.operation)
            OP_KEY_BYTE, OP_KEY_END: begin
               if (phase != PHASE_KEY) begin_load(PHASE_KEY);
               if (r.operation == OP_KEY_BYTE) pack_byte(r.data_byte);
               else close_load(1);
            end
            OP_NONCE_BYTE, OP_NONCE_END: begin
               if (phase != PHASE_NONCE) begin_load(PHASE_NONCE);
               if (r.operation == OP_NONCE_BYTE) pack_byte(r.data_byte);
               else close_load(0);
            end
            OP_ENCRYPT, OP_DECRYPT: begin
               phase = PHASE_IDLE;
               if (bits_left == 0) begin
                  advance();
                  mac_acc = 0;
                  bits_left = 32;
               end
               ks = 8'(keystream >> (32 - bits_left));
               res = r.data_byte ^ ks;
               plain = (r.operation == OP_ENCRYPT) ? r.data_byte : res;
               mac_acc ^= 32'(plain) << (32 - bits_left);
               bits_left -= 8;
               if (bits_left == 0) absorb_word(mac_acc);
               e.result_byte = res;
               pending.push_back(e);
            end
            OP_FINISH: begin
               phase = PHASE_IDLE;
               if (bits_left != 0) absorb_word(mac_acc);
               advance();
               regs[KEY_POS] ^= INIT_KONST ^ 32'(bits_left << 3);
               bits_left = 0;
               for (int i = 0; i < 16; i++) regs[i] ^= crcs[i];
               for (int i = 0; i < FOLD_ROUNDS; i++) advance();
               advance();
               e.mac_word = keystream;
               e.is_mac = 1'b1;
               pending.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         e = pending.pop_front();
         if (got.result_byte !== e.result_byte || got.mac_word !== e.mac_word ||
             got.is_mac !== e.is_mac) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected byte %h mac %h flag %b, got byte %h mac %h flag %b",
                        e.result_byte, e.mac_word, e.is_mac,
                        got.result_byte, got.mac_word, got.is_mac);
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   cipher_scoreboard mac_board = new();
   int unsigned send_idle_pct = 0;   // chance per cycle the sender idles
   int unsigned recv_stall_pct = 0;  // chance per cycle the receiver stalls
   int unsigned hold_cycles = 0;     // long receiver hold-off, counted below

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   shannon_stream_cipher_mac i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Receiver: random stall, or a long hold-off while hold_cycles runs down.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) mac_board.check_result(rsp_data);
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Offer one request; hold it until accepted, noting it in the scoreboard.
   // Valid stays high after acceptance so requests can follow back to back;
   // it drops only when the sender idles or drains.
   task automatic send_request(op_type op, logic [7:0] b);
      req_type r;
      r.operation = op;
      r.data_byte = b;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mac_board.note_request(r);
   endtask

   // Wait until every expected result is back, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (mac_board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic load_material(op_type byte_op, op_type end_op, int unsigned n);
      for (int i = 0; i < n; i++) send_request(byte_op, 8'($urandom_range(255)));
      send_request(end_op, 8'($urandom_range(255)));
   endtask

   // A well-formed session: key (sometimes), nonce, message, finish.
   task automatic session();
      if ($urandom_range(3) == 0) load_material(OP_KEY_BYTE, OP_KEY_END, $urandom_range(0, 20));
      load_material(OP_NONCE_BYTE, OP_NONCE_END, $urandom_range(0, 12));
      repeat ($urandom_range(0, 30))
         send_request($urandom_range(1) ? OP_ENCRYPT : OP_DECRYPT, 8'($urandom_range(255)));
      send_request(OP_FINISH, 8'($urandom_range(255)));
   endtask

   task automatic noise_items(int unsigned n);
      repeat (n) send_request(op_type'($urandom_range(7)), 8'($urandom_range(255)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: never keyed, empty key and nonce, extremes, partial words, broken loads
      send_request(OP_ENCRYPT, 8'h00);
      send_request(OP_DECRYPT, 8'hff);
      send_request(OP_FINISH, 8'hff);
      send_request(OP_KEY_END, 8'h00);
      send_request(OP_NONCE_END, 8'hff);
      send_request(OP_ENCRYPT, 8'hff);
      send_request(OP_FINISH, 8'h00);
      send_request(OP_UNUSED, 8'ha5);
      send_request(OP_KEY_BYTE, 8'hff);
      send_request(OP_KEY_BYTE, 8'h00);
      send_request(OP_NONCE_BYTE, 8'h5a);  // abandons the key load
      send_request(OP_KEY_BYTE, 8'h81);    // abandons the nonce load
      send_request(OP_ENCRYPT, 8'h3c);     // interrupts a load
      send_request(OP_KEY_BYTE, 8'h12);
      send_request(OP_KEY_BYTE, 8'h34);
      send_request(OP_KEY_BYTE, 8'h56);
      send_request(OP_KEY_BYTE, 8'h78);
      send_request(OP_KEY_BYTE, 8'h9a);
      send_request(OP_KEY_END, 8'h00);
      send_request(OP_NONCE_BYTE, 8'h01);
      send_request(OP_NONCE_END, 8'h00);
      send_request(OP_DECRYPT, 8'h80);
      send_request(OP_ENCRYPT, 8'h7f);
      send_request(OP_FINISH, 8'h00);
      drain();

      // random phases with different idling mixes
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? 76 : (ph == 2 ? 0 : 0);
         recv_stall_pct = (ph == 2 || ph == 3) ? 76 : 0;
         if (ph == 3) begin
            send_idle_pct = 7;
            recv_stall_pct = 7;
         end
         if (ph == 2) hold_cycles = 300;  // block fills and stalls its input
         for (int n = 0; n < 10; n++) begin
            if ($urandom_range(4) == 0) noise_items($urandom_range(1, 6));
            else session();
         end
         drain();  // sender pauses until every result is back
      end

      drain();
      if (mac_board.mismatches == 0 && mac_board.pending.size() == 0)
         $display("shannon_stream_cipher_mac verification clean");
      else
         $display("shannon_stream_cipher_mac verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("shannon_stream_cipher_mac verification failed");
      $finish;
   end
endmodule
